@@ hdl/kts_pkg.sv @@
`default_nettype none

package kts_pkg;

    // Width of the position and length counters; they saturate at all ones.
    localparam int PosBits   = 16;
    localparam int FieldBits = 16;

    typedef logic [PosBits-1:0]   pos_t;
    typedef logic [FieldBits-1:0] field_t;

    typedef enum logic [3:0] {
        KIND_END    = 4'd0,
        KIND_IDENT  = 4'd1,
        KIND_NUMBER = 4'd2,
        KIND_INT    = 4'd3,
        KIND_PRINT  = 4'd4,
        KIND_IF     = 4'd5,
        KIND_ELSE   = 4'd6,
        KIND_ASSIGN = 4'd7,
        KIND_PLUS   = 4'd8,
        KIND_MINUS  = 4'd9,
        KIND_STAR   = 4'd10,
        KIND_SLASH  = 4'd11,
        KIND_LPAREN = 4'd12,
        KIND_RPAREN = 4'd13,
        KIND_GT     = 4'd14,
        KIND_LT     = 4'd15
    } kind_t;

    typedef struct packed {
        kind_t  kind;
        field_t start;
        field_t length;
        logic   last;
    } token_t;

    // Keyword bytes, first byte in the low bits
    localparam logic [39:0] KwInt   = 40'h00_0074_6E69;
    localparam logic [39:0] KwPrint = 40'h74_6E69_7270;
    localparam logic [39:0] KwIf    = 40'h00_0000_6669;
    localparam logic [39:0] KwElse  = 40'h00_6573_6C65;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    // Operator byte to kind; KIND_END means not an operator
    function automatic kind_t op_kind(input logic [7:0] c);
        kind_t k;
        case (c)
            8'h3D:   k = KIND_ASSIGN;
            8'h2B:   k = KIND_PLUS;
            8'h2D:   k = KIND_MINUS;
            8'h2A:   k = KIND_STAR;
            8'h2F:   k = KIND_SLASH;
            8'h28:   k = KIND_LPAREN;
            8'h29:   k = KIND_RPAREN;
            8'h3E:   k = KIND_GT;
            8'h3C:   k = KIND_LT;
            default: k = KIND_END;
        endcase
        return k;
    endfunction

    // Keywords need both the exact length and the exact bytes
    function automatic kind_t ident_kind(input pos_t len, input logic [39:0] prefix);
        kind_t k;
        if (len == PosBits'(3) && prefix == KwInt)
            k = KIND_INT;
        else if (len == PosBits'(5) && prefix == KwPrint)
            k = KIND_PRINT;
        else if (len == PosBits'(2) && prefix == KwIf)
            k = KIND_IF;
        else if (len == PosBits'(4) && prefix == KwElse)
            k = KIND_ELSE;
        else
            k = KIND_IDENT;
        return k;
    endfunction

    function automatic pos_t sat_inc(input pos_t v);
        return (v == '1) ? v : v + PosBits'(1);
    endfunction

endpackage

`default_nettype wire

@@ hdl/keyword_token_scanner.sv @@
`default_nettype none

// Byte-serial tokenizer for a small C-like language.
// Slave stream: one source byte per word in s_axis_tdata; s_axis_tlast marks
// the end of the text (a zero byte does the same, and the byte is not used).
// Master stream: one token per word, given as kind, start offset and length;
// m_axis_tlast flags the final token caused by one input byte.
// Each accepted byte lands in an input register; the scanner logic then moves
// it into a two-entry token register once that register has room for its
// tokens, so a byte's tokens pass through both registers to the master side.
// Throughput is one byte per cycle while the token register has room. A byte
// yielding two tokens (a token closed by an operator, or a pending token and
// END) fills the token register, so a following byte with a token waits.
// If the receiver stalls, bytes that yield no token keep flowing; the first
// byte that yields a token waits in the input register and s_axis_tready
// drops until the token register drains.
// At the end of a text the pending token and then END (length 0) are sent
// and the scanner goes back to the start of a new text.
// Reset clears all state: idle mode, position zero, both registers empty.
module keyword_token_scanner (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] ch
    input  wire logic        s_axis_tlast,   // is_end
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output      logic [31:0] m_axis_tdata,   // [15:0] token_start, [31:16] token_length
    output      logic [3:0]  m_axis_tuser,   // [3:0] token_kind
    output      logic        m_axis_tlast    // last_of_run
);
    import kts_pkg::*;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_IDENT = 2'd1,
        MODE_NUM   = 2'd2
    } mode_t;

    // Input register
    logic       in_valid_reg;
    logic [7:0] in_ch_reg;
    logic       in_end_reg;

    // Scanner state
    mode_t       mode_reg,      mode_next;
    pos_t        pos_reg,       pos_next;
    pos_t        pstart_reg,    pstart_next;
    pos_t        plen_reg,      plen_next;
    logic [39:0] prefix_reg,    prefix_next;

    // Token register: slot0 is presented on the master side
    token_t     slot0_reg, slot0_next;
    token_t     slot1_reg, slot1_next;
    logic [1:0] cnt_reg,   cnt_next;

    logic       end_f, alpha, digit, cont, flush, second_vld;
    kind_t      opk;
    token_t     pend_tok, second_tok, r0, r1;
    logic [1:0] n_res;
    logic       pop, free, advance;

    always_comb
    begin
        end_f = in_end_reg || (in_ch_reg == 8'h00);
        alpha = is_alpha(in_ch_reg);
        digit = is_digit(in_ch_reg);
        opk   = op_kind(in_ch_reg);
        cont  = !end_f && (((mode_reg == MODE_IDENT) && (alpha || digit)) ||
                           ((mode_reg == MODE_NUM) && digit));
        flush = (mode_reg != MODE_IDLE) && !cont;

        pend_tok.kind   = (mode_reg == MODE_IDENT) ? ident_kind(plen_reg, prefix_reg)
                                                   : KIND_NUMBER;
        pend_tok.start  = FieldBits'(pstart_reg);
        pend_tok.length = FieldBits'(plen_reg);
        pend_tok.last   = 1'b0;

        // END, or a one-byte operator
        second_tok.kind   = end_f ? KIND_END : opk;
        second_tok.start  = FieldBits'(pos_reg);
        second_tok.length = end_f ? '0 : FieldBits'(1);
        second_tok.last   = 1'b1;
        second_vld = end_f || (!cont && !alpha && !digit && (opk != KIND_END));

        if (flush)
        begin
            r0      = pend_tok;
            r0.last = !second_vld;
            r1      = second_tok;
            n_res   = second_vld ? 2'd2 : 2'd1;
        end
        else
        begin
            r0    = second_tok;
            r1    = second_tok;
            n_res = second_vld ? 2'd1 : 2'd0;
        end

        // Next scanner state
        mode_next   = mode_reg;
        pos_next    = sat_inc(pos_reg);
        pstart_next = pstart_reg;
        plen_next   = plen_reg;
        prefix_next = prefix_reg;
        if (end_f)
        begin
            mode_next   = MODE_IDLE;
            pos_next    = '0;
            pstart_next = '0;
            plen_next   = '0;
            prefix_next = '0;
        end
        else if (cont)
        begin
            plen_next = sat_inc(plen_reg);
            if (mode_reg == MODE_IDENT)
            begin
                for (int i = 0; i < 5; i++)
                begin
                    if (plen_reg == PosBits'(i))
                        prefix_next[8*i +: 8] = prefix_reg[8*i +: 8] | in_ch_reg;
                end
            end
        end
        else if (alpha)
        begin
            mode_next   = MODE_IDENT;
            pstart_next = pos_reg;
            plen_next   = PosBits'(1);
            prefix_next = {32'h0, in_ch_reg};
        end
        else if (digit)
        begin
            mode_next   = MODE_NUM;
            pstart_next = pos_reg;
            plen_next   = PosBits'(1);
            prefix_next = '0;
        end
        else
        begin
            mode_next = MODE_IDLE;
        end
    end

    // Handshake and token register
    always_comb
    begin
        pop     = (cnt_reg != 2'd0) && m_axis_tready;
        free    = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && pop);
        advance = in_valid_reg && (free || (n_res == 2'd0));

        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        cnt_next   = cnt_reg;
        if (pop)
        begin
            slot0_next = slot1_reg;
            cnt_next   = cnt_reg - 2'd1;
        end
        if (advance && (n_res != 2'd0))
        begin
            slot0_next = r0;
            slot1_next = r1;
            cnt_next   = n_res;
        end
    end

    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = (cnt_reg != 2'd0);
    assign m_axis_tdata  = {slot0_reg.length, slot0_reg.start};
    assign m_axis_tuser  = slot0_reg.kind;
    assign m_axis_tlast  = slot0_reg.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            in_ch_reg    <= '0;
            in_end_reg   <= 1'b0;
            mode_reg     <= MODE_IDLE;
            pos_reg      <= '0;
            pstart_reg   <= '0;
            plen_reg     <= '0;
            prefix_reg   <= '0;
            slot0_reg    <= '0;
            slot1_reg    <= '0;
            cnt_reg      <= 2'd0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                in_valid_reg <= 1'b1;
                in_ch_reg    <= s_axis_tdata;
                in_end_reg   <= s_axis_tlast;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                mode_reg   <= mode_next;
                pos_reg    <= pos_next;
                pstart_reg <= pstart_next;
                plen_reg   <= plen_next;
                prefix_reg <= prefix_next;
            end
            slot0_reg <= slot0_next;
            slot1_reg <= slot1_next;
            cnt_reg   <= cnt_next;
        end
    end

    // The token register never holds more than two tokens
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("token register overfilled");

    // With two tokens queued, the one shown is never the last of its byte
    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2) |-> !m_axis_tlast)
        else $error("first of a token pair flagged last");

    // END always closes the run of its byte and has zero length
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == KIND_END)) |->
            (m_axis_tlast && (m_axis_tdata[31:16] == 16'h0000)))
        else $error("END token malformed");

    // A byte waiting in the input register is never dropped
    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_ch_reg)))
        else $error("stalled input byte lost");

endmodule

`default_nettype wire

@@ sim/kts_token_checker.sv @@
module kts_token_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] ch
    input  logic        s_axis_tlast,   // is_end
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,   // [15:0] token_start, [31:16] token_length
    input  logic [3:0]  m_axis_tuser,   // [3:0] token_kind
    input  logic        m_axis_tlast,   // last_of_run
    output int          fail_count,
    output int          tokens_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import kts_pkg::*;

    typedef enum logic [1:0] {SCAN_IDLE, SCAN_WORD, SCAN_NUMBER} scan_t;
    typedef enum logic [2:0] {
        CLASS_LETTER, CLASS_DIGIT, CLASS_BLANK, CLASS_OPER, CLASS_OTHER
    } byte_class_t;

    // Keyword spellings, first byte in the low bits
    localparam logic [39:0] SPELL_INT   = {16'h0, "t", "n", "i"};
    localparam logic [39:0] SPELL_PRINT = {"t", "n", "i", "r", "p"};
    localparam logic [39:0] SPELL_IF    = {24'h0, "f", "i"};
    localparam logic [39:0] SPELL_ELSE  = {8'h0, "e", "s", "l", "e"};
    localparam pos_t        POS_TOP     = '1;

    scan_t        mode;
    pos_t         pos;
    pos_t         tok_start;
    pos_t         tok_len;
    logic [39:0]  prefix;
    token_t       tokens_due[$];
    int           mismatches;

    function automatic kind_t oper_kind(input logic [7:0] c);
        case (c)
            "=":     return KIND_ASSIGN;
            "+":     return KIND_PLUS;
            "-":     return KIND_MINUS;
            "*":     return KIND_STAR;
            "/":     return KIND_SLASH;
            "(":     return KIND_LPAREN;
            ")":     return KIND_RPAREN;
            ">":     return KIND_GT;
            "<":     return KIND_LT;
            default: return KIND_END;
        endcase
    endfunction

    function automatic byte_class_t classify(input logic [7:0] c);
        if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z"))
            return CLASS_LETTER;
        if (c >= "0" && c <= "9")
            return CLASS_DIGIT;
        if (c == " " || (c >= 8'd9 && c <= 8'd13))
            return CLASS_BLANK;
        if (oper_kind(c) != KIND_END)
            return CLASS_OPER;
        return CLASS_OTHER;
    endfunction

    function automatic pos_t bump(input pos_t v);
        return (v == POS_TOP) ? v : v + 1'b1;
    endfunction

    function automatic token_t make_token(input kind_t k, input pos_t at, input pos_t len);
        token_t t;
        t.kind   = k;
        t.start  = field_t'(at);
        t.length = field_t'(len);
        t.last   = 1'b0;
        return t;
    endfunction

    // Emit the identifier or number in progress, if any, and go idle
    task automatic close_word(output bit got, output token_t t);
        kind_t k;
        got = 1'b0;
        t   = '0;
        if (mode == SCAN_WORD)
        begin
            if (tok_len == 3 && prefix == SPELL_INT)
                k = KIND_INT;
            else if (tok_len == 5 && prefix == SPELL_PRINT)
                k = KIND_PRINT;
            else if (tok_len == 2 && prefix == SPELL_IF)
                k = KIND_IF;
            else if (tok_len == 4 && prefix == SPELL_ELSE)
                k = KIND_ELSE;
            else
                k = KIND_IDENT;
            t   = make_token(k, tok_start, tok_len);
            got = 1'b1;
        end
        else if (mode == SCAN_NUMBER)
        begin
            t   = make_token(KIND_NUMBER, tok_start, tok_len);
            got = 1'b1;
        end
        mode = SCAN_IDLE;
    endtask

    task automatic restart_text();
        mode      = SCAN_IDLE;
        pos       = '0;
        tok_start = '0;
        tok_len   = '0;
        prefix    = '0;
    endtask

    // Advance the scanner by one byte and queue the tokens it yields
    task automatic scan_byte(input logic [7:0] c, input logic ends);
        byte_class_t cl;
        bit          has_word;
        bit          has_tail;
        token_t      word_tok;
        token_t      tail_tok;
        has_word = 1'b0;
        has_tail = 1'b0;
        word_tok = '0;
        tail_tok = '0;
        cl       = classify(c);
        if (ends || c == 8'h00)
        begin
            close_word(has_word, word_tok);
            tail_tok = make_token(KIND_END, pos, '0);
            has_tail = 1'b1;
            restart_text();
        end
        else if ((mode == SCAN_WORD && (cl == CLASS_LETTER || cl == CLASS_DIGIT)) ||
                 (mode == SCAN_NUMBER && cl == CLASS_DIGIT))
        begin
            if (mode == SCAN_WORD && tok_len < 5)
                prefix[8*tok_len +: 8] = c;
            tok_len = bump(tok_len);
            pos     = bump(pos);
        end
        else
        begin
            close_word(has_word, word_tok);
            case (cl)
                CLASS_LETTER:
                begin
                    mode      = SCAN_WORD;
                    tok_start = pos;
                    tok_len   = pos_t'(1);
                    prefix    = {32'h0, c};
                end
                CLASS_DIGIT:
                begin
                    mode      = SCAN_NUMBER;
                    tok_start = pos;
                    tok_len   = pos_t'(1);
                    prefix    = '0;
                end
                CLASS_OPER:
                begin
                    tail_tok = make_token(oper_kind(c), pos, pos_t'(1));
                    has_tail = 1'b1;
                end
                default: ;
            endcase
            pos = bump(pos);
        end
        if (has_word)
        begin
            word_tok.last = !has_tail;
            tokens_due    = {tokens_due, word_tok};
        end
        if (has_tail)
        begin
            tail_tok.last = 1'b1;
            tokens_due    = {tokens_due, tail_tok};
        end
    endtask

    task automatic note_fail(input string what, input int want, input int seen);
        mismatches++;
        $display("%0t: %s expected %0d, got %0d", $time, what, want, seen);
    endtask

    task automatic check_token();
        token_t want;
        token_t seen;
        seen.kind   = kind_t'(m_axis_tuser);
        seen.start  = m_axis_tdata[15:0];
        seen.length = m_axis_tdata[31:16];
        seen.last   = m_axis_tlast;
        if (tokens_due.size() == 0)
        begin
            mismatches++;
            $display("%0t: unexpected token, expected none, got kind %0d start %0d len %0d",
                     $time, seen.kind, seen.start, seen.length);
        end
        else
        begin
            want = tokens_due.pop_front();
            if (seen.kind != want.kind)
                note_fail("token_kind", int'(want.kind), int'(seen.kind));
            if (seen.start != want.start)
                note_fail("token_start", int'(want.start), int'(seen.start));
            if (seen.length != want.length)
                note_fail("token_length", int'(want.length), int'(seen.length));
            if (seen.last != want.last)
                note_fail("last_of_run", int'(want.last), int'(seen.last));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restart_text();
            tokens_due.delete();
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                scan_byte(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
                check_token();
            fail_count     <= mismatches;
            tokens_pending <= tokens_due.size();
        end
    end

endmodule

@@ sim/tb_keyword_token_scanner.sv @@
module tb_keyword_token_scanner;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;   // [7:0] ch
    logic        s_axis_tlast  = 1'b0;    // is_end
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;            // [15:0] token_start, [31:16] token_length
    logic [3:0]  m_axis_tuser;            // [3:0] token_kind
    logic        m_axis_tlast;            // last_of_run

    int          fail_count;
    int          tokens_pending;
    int          words_sent;
    bit          quiet_tx;   // sender runs back to back while set
    bit          quiet_rx;   // receiver never stalls while set

    string keywords   [4]  = '{"int", "print", "if", "else"};
    // Spellings near a keyword: a byte short or extra, or letters in another case
    string near_words [12] = '{"in", "iff", "prin", "prints", "els", "elses",
                               "Int", "IF", "printx", "int0", "if9", "elsE"};
    string operators       = "=+-*/()><";

    always #5 clk = ~clk;

    keyword_token_scanner u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    kts_token_checker u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tlast   (s_axis_tlast),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .m_axis_tlast   (m_axis_tlast),
        .fail_count     (fail_count),
        .tokens_pending (tokens_pending)
    );

    // Offer one source word after a random gap and hold it until taken.
    // tvalid stays high on return so the next word can follow without a bubble.
    task automatic push_word(input logic [7:0] b, input logic ends);
        int gap;
        gap = quiet_tx ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= ends;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        words_sent++;
    endtask

    task automatic push_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            push_word(s[i], 1'b0);
    endtask

    // Drop tvalid and hold off until every predicted token has come out
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (tokens_pending != 0) @(posedge clk);
    endtask

    function automatic logic [7:0] rand_letter();
        return $urandom_range(0, 1) ? 8'(8'h61 + $urandom_range(0, 25))
                                    : 8'(8'h41 + $urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] rand_alnum();
        return ($urandom_range(0, 2) == 0) ? 8'(8'h30 + $urandom_range(0, 9))
                                           : rand_letter();
    endfunction

    // Receiver: stall a random number of cycles before each word, with
    // occasional stretches of no stalls at all
    initial
    begin
        int stall;
        quiet_rx = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                quiet_rx = !quiet_rx;
            stall = quiet_rx ? 0 : $urandom_range(0, 17);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid) @(posedge clk);
        end
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #15_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        int n;
        quiet_tx   = 1'b0;
        words_sent = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed texts: keywords closed by blanks and by the end mark
        // (with a ch of all ones that must be ignored), every operator, a
        // word and a number closed by operators, a non-ASCII byte, a zero
        // byte as terminator, and an empty text.
        push_text("if else");
        push_word(8'hFF, 1'b1);
        push_text("int=5+-*/()><");
        push_word(8'h80, 1'b0);
        push_word(8'h00, 1'b0);
        push_text("print");
        push_word(8'h00, 1'b1);
        push_word(8'h41, 1'b1);

        // Hold the sender until the block has fully drained
        drain();

        // Random texts: mostly well-formed token sequences, some raw noise
        words_sent = 0;
        while (words_sent < 1150)
        begin
            quiet_tx = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) == 0)
            begin
                repeat ($urandom_range(1, 30))
                    push_word(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
            end
            else
            begin
                repeat ($urandom_range(0, 10))
                begin
                    case ($urandom_range(0, 7))
                        0: push_text(keywords[$urandom_range(0, 3)]);
                        1: push_text(near_words[$urandom_range(0, 11)]);
                        2, 3:
                        begin
                            n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 11)
                                                            : $urandom_range(0, 4);
                            push_word(rand_letter(), 1'b0);
                            repeat (n) push_word(rand_alnum(), 1'b0);
                        end
                        4, 5:
                        begin
                            n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 12)
                                                            : $urandom_range(1, 5);
                            repeat (n) push_word(8'(8'h30 + $urandom_range(0, 9)), 1'b0);
                        end
                        default: push_word(operators[$urandom_range(0, 8)], 1'b0);
                    endcase
                    // Separator: none (tokens abut), blank, a non-ASCII byte, or a random ASCII byte
                    case ($urandom_range(0, 5))
                        2: push_word(8'h20, 1'b0);
                        3: push_word(8'(8'd9 + $urandom_range(0, 4)), 1'b0);
                        4: push_word(8'($urandom_range(128, 255)), 1'b0);
                        5: push_word(8'($urandom_range(1, 127)), 1'b0);
                        default: ;
                    endcase
                end
                // Terminate by the end mark or by a zero byte
                if ($urandom_range(0, 1))
                    push_word(8'($urandom_range(0, 255)), 1'b1);
                else
                    push_word(8'h00, 1'b0);
            end
        end

        drain();
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ keyword_token_scanner.f @@
hdl/kts_pkg.sv
hdl/keyword_token_scanner.sv
sim/kts_token_checker.sv
sim/tb_keyword_token_scanner.sv
